@@ hdl/sipq_pkg.sv @@
// shared types and codes of the sorted insert priority queue
package sipq_pkg;

    localparam int FILL_W   = 8;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ       = 2'd0,
        MODE_DEQ       = 2'd1,
        MODE_PEEK_HEAD = 2'd2,
        MODE_PEEK_TAIL = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic enq;
        logic deq;
    } sipq_ctl_t;

endpackage

@@ hdl/sipq_cell.sv @@
// one slot of the sorted row: holds an entry, compares, shifts with its neighbors
module sipq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int PRIO_WIDTH = 8,
    parameter int COUNT_W    = 8,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  sipq_pkg::sipq_ctl_t   ctl,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic [PRIO_WIDTH-1:0] new_prio,
    input  logic [COUNT_W-1:0]    count,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [PRIO_WIDTH-1:0] left_prio,
    input  logic                  left_ge,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [PRIO_WIDTH-1:0] right_prio,
    output logic [DATA_WIDTH-1:0] ent_data,
    output logic [PRIO_WIDTH-1:0] ent_prio,
    output logic                  ge
);
    import sipq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;
    logic                  occupied;

    assign occupied = count > COUNT_W'(INDEX);
    // entry stays ahead of a new one of lower or equal priority
    assign ge       = occupied && (prio_reg >= new_prio);
    assign ent_data = data_reg;
    assign ent_prio = prio_reg;

    always_comb begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctl.enq) begin
            if (!ge) begin
                if (left_ge) begin
                    data_next = new_data;
                    prio_next = new_prio;
                end else begin
                    data_next = left_data;
                    prio_next = left_prio;
                end
            end
        end else if (ctl.deq) begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

@@ hdl/sorted_insert_priority_queue.sv @@
// top level of the sorted insert priority queue: cell row, tail copy, result register
//
// Each beat on the s_ channel is one request: enqueue, dequeue head, peek head or
// peek tail. Each request yields exactly one beat on the m_ channel carrying the
// status, the dequeued or peeked entry (zero for enqueue and errors) and the fill
// count after the request. Entries sit in a row of DEPTH cells, highest priority
// in cell 0; equal priorities keep arrival order.
// On an enqueue every cell compares the new priority with its
// own at once and either keeps, takes the new entry or takes its left neighbor.
// A dequeue shifts the whole row one cell toward the head in the same cycle.
// The tail is kept in a separate copy so peek tail needs no wide read mux.
// The result beat comes in the cycle after the request beat, and the block
// takes one request per cycle while the result register is empty or being read.
// When the receiver stalls, the result holds and s_tready drops until it is taken.
// Reset empties the queue and the result register; cell contents are not cleared.
module sorted_insert_priority_queue #(
    parameter int DEPTH      = 128,
    parameter int PRIO_WIDTH = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // mode, item_data, item_priority, zero pad
    input  logic [((sipq_pkg::MODE_W+DATA_WIDTH+PRIO_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, out_data, out_priority, fill_count, zero pad
    output logic [((sipq_pkg::STATUS_W+DATA_WIDTH+PRIO_WIDTH+sipq_pkg::FILL_W+7)/8)*8-1:0]
                                 m_tdata
);
    import sipq_pkg::*;

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W   = ((STATUS_W + DATA_WIDTH + PRIO_WIDTH + FILL_W + 7) / 8) * 8;

    mode_t                 in_mode;
    logic [DATA_WIDTH-1:0] in_data;
    logic [PRIO_WIDTH-1:0] in_prio;
    logic                  in_beat;

    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [DATA_WIDTH-1:0] tail_data_reg, tail_data_next;
    logic [PRIO_WIDTH-1:0] tail_prio_reg, tail_prio_next;
    logic                  res_valid_reg, res_valid_next;
    logic [OUT_W-1:0]      res_reg, res_next;

    sipq_ctl_t             ctl;
    status_t               status;
    logic [DATA_WIDTH-1:0] res_data;
    logic [PRIO_WIDTH-1:0] res_prio;
    logic                  full, empty;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
    logic [DEPTH-1:0]      cell_ge;

    assign in_mode = mode_t'(s_tdata[MODE_W-1:0]);
    assign in_data = s_tdata[MODE_W+DATA_WIDTH-1:MODE_W];
    assign in_prio = s_tdata[MODE_W+DATA_WIDTH+PRIO_WIDTH-1:MODE_W+DATA_WIDTH];

    assign s_tready = !res_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign full     = count_reg == COUNT_W'(DEPTH);
    assign empty    = count_reg == '0;

    assign ctl.enq = in_beat && (in_mode == MODE_ENQ) && !full;
    assign ctl.deq = in_beat && (in_mode == MODE_DEQ) && !empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] l_data, r_data;
        logic [PRIO_WIDTH-1:0] l_prio, r_prio;
        logic                  l_ge;

        if (i == 0) begin : g_head
            // head cell: nothing to the left, a non-ge head takes the new entry
            assign l_data = in_data;
            assign l_prio = in_prio;
            assign l_ge   = 1'b1;
        end else begin : g_mid
            assign l_data = cell_data[i-1];
            assign l_prio = cell_prio[i-1];
            assign l_ge   = cell_ge[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_data = cell_data[i];
            assign r_prio = cell_prio[i];
        end else begin : g_inner
            assign r_data = cell_data[i+1];
            assign r_prio = cell_prio[i+1];
        end

        sipq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH),
            .COUNT_W    (COUNT_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .new_data   (in_data),
            .new_prio   (in_prio),
            .count      (count_reg),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .left_ge    (l_ge),
            .right_data (r_data),
            .right_prio (r_prio),
            .ent_data   (cell_data[i]),
            .ent_prio   (cell_prio[i]),
            .ge         (cell_ge[i])
        );
    end

    // result of the current request and next count
    always_comb begin
        status     = ST_OK;
        res_data   = '0;
        res_prio   = '0;
        count_next = count_reg;
        unique case (in_mode)
            MODE_ENQ: begin
                if (full) begin
                    status = ST_OVERFLOW;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_DEQ: begin
                if (empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    res_data   = cell_data[0];
                    res_prio   = cell_prio[0];
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_PEEK_HEAD: begin
                if (empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    res_data = cell_data[0];
                    res_prio = cell_prio[0];
                end
            end
            MODE_PEEK_TAIL: begin
                if (empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    res_data = tail_data_reg;
                    res_prio = tail_prio_reg;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // tail copy: changes only when the new entry lands behind every held one
    always_comb begin
        tail_data_next = tail_data_reg;
        tail_prio_next = tail_prio_reg;
        if (ctl.enq && (empty || tail_prio_reg >= in_prio)) begin
            tail_data_next = in_data;
            tail_prio_next = in_prio;
        end
    end

    always_comb begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (in_beat) begin
            res_valid_next = 1'b1;
            res_next       = OUT_W'({FILL_W'(count_next), res_prio, res_data, status});
        end else if (m_tready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            count_reg     <= in_beat ? count_next : count_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_data_reg <= tail_data_next;
        tail_prio_reg <= tail_prio_next;
        res_reg       <= res_next;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(DEPTH))
        else $error("fill count above depth");

    a_underflow_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && empty && in_mode != MODE_ENQ) |=> (count_reg == '0))
        else $error("underflow request changed the fill count");

    a_overflow_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && full && in_mode == MODE_ENQ) |=> (count_reg == COUNT_W'(DEPTH)))
        else $error("overflow request changed the fill count");

    a_head_vs_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> (cell_prio[0] >= tail_prio_reg))
        else $error("head priority below tail priority");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !m_tready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("result lost while receiver stalled");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the sorted insert priority queue over its stream ports
module tb;
    import sipq_pkg::*;

    localparam int QDEPTH  = 128;
    localparam int PRIO_W  = 8;
    localparam int DATA_W  = 32;
    localparam int S_W     = ((MODE_W + DATA_W + PRIO_W + 7) / 8) * 8;
    localparam int M_W     = ((STATUS_W + DATA_W + PRIO_W + FILL_W + 7) / 8) * 8;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        logic [FILL_W-1:0] fill;
    } result_t;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    // mode, item_data, item_priority, zero pad
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    // status, out_data, out_priority, fill_count, zero pad
    logic [M_W-1:0] m_tdata;

    // queue contents as the block should hold them, head first
    entry_t  held_entries[$];
    result_t pending_results[$];

    int  fail_count     = 0;
    int  reqs_sent      = 0;
    int  results_seen   = 0;
    int  overflow_seen  = 0;
    int  underflow_seen = 0;
    int  hold_cycles    = 0;
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;

    always #10 aclk = ~aclk;

    sorted_insert_priority_queue #(
        .DEPTH     (QDEPTH),
        .PRIO_WIDTH(PRIO_W),
        .DATA_WIDTH(DATA_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // applies one request to the expected queue contents and returns its result
    function automatic result_t apply_request(mode_t mode, logic [DATA_W-1:0] data,
                                              logic [PRIO_W-1:0] prio);
        result_t r;
        entry_t  e;
        int      pos;
        r = '{status: ST_OK, data: '0, prio: '0, fill: '0};
        if (mode == MODE_ENQ) begin
            if (held_entries.size() >= QDEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                // new entry goes behind every entry of greater or equal priority
                pos = held_entries.size();
                while (pos > 0 && held_entries[pos-1].prio < prio)
                    pos--;
                e.data = data;
                e.prio = prio;
                held_entries.insert(pos, e);
            end
        end else if (held_entries.size() == 0) begin
            r.status = ST_UNDERFLOW;
        end else if (mode == MODE_DEQ) begin
            e = held_entries.pop_front();
            r.data = e.data;
            r.prio = e.prio;
        end else if (mode == MODE_PEEK_HEAD) begin
            r.data = held_entries[0].data;
            r.prio = held_entries[0].prio;
        end else begin
            r.data = held_entries[$].data;
            r.prio = held_entries[$].prio;
        end
        r.fill = FILL_W'(held_entries.size());
        return r;
    endfunction

    function automatic mode_t pick_mode(int enq_pct, int deq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            return MODE_ENQ;
        if (r < enq_pct + deq_pct)
            return MODE_DEQ;
        return (r % 2 == 0) ? MODE_PEEK_HEAD : MODE_PEEK_TAIL;
    endfunction

    // offers one request and returns at the edge where it is taken; valid stays up
    task automatic send_req(mode_t mode, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] prio);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W-MODE_W-DATA_W-PRIO_W){1'b0}}, prio, data, mode};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_request(mode, data, prio));
        reqs_sent++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed();
        // empty queue: every read reports underflow
        send_req(MODE_DEQ, $urandom, 8'($urandom));
        send_req(MODE_PEEK_HEAD, $urandom, 8'($urandom));
        send_req(MODE_PEEK_TAIL, $urandom, 8'($urandom));
        // extremes of data and priority, ties at the top priority and in the middle
        send_req(MODE_ENQ, 32'h7fff_ffff, 8'hff);
        send_req(MODE_ENQ, 32'h8000_0000, 8'h00);
        send_req(MODE_ENQ, 32'h0000_0000, 8'h80);
        send_req(MODE_ENQ, 32'hffff_ffff, 8'h80);
        send_req(MODE_ENQ, 32'h0000_0001, 8'hff);
        send_req(MODE_PEEK_HEAD, $urandom, 8'($urandom));
        send_req(MODE_PEEK_TAIL, $urandom, 8'($urandom));
        repeat (5) send_req(MODE_DEQ, $urandom, 8'($urandom));
        send_req(MODE_DEQ, $urandom, 8'($urandom));
        send_req(MODE_ENQ, 32'h5555_5555, 8'haa);
        send_req(MODE_ENQ, 32'haaaa_aaaa, 8'h55);
        send_req(MODE_PEEK_TAIL, $urandom, 8'($urandom));
        send_req(MODE_DEQ, $urandom, 8'($urandom));
        send_req(MODE_DEQ, $urandom, 8'($urandom));
        wait_results_done();
    endtask

    task automatic test_fill_overflow();
        int prio_hi;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        while (held_entries.size() < QDEPTH) begin
            // narrow priorities now and then to pile up ties
            prio_hi = ($urandom_range(0, 3) == 0) ? 3 : 255;
            send_req(MODE_ENQ, $urandom, 8'($urandom_range(0, prio_hi)));
        end
        repeat (4) send_req(MODE_ENQ, $urandom, 8'($urandom));
        send_req(MODE_PEEK_HEAD, $urandom, 8'($urandom));
        send_req(MODE_PEEK_TAIL, $urandom, 8'($urandom));
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        while (held_entries.size() > 0)
            send_req(pick_mode(0, 80), $urandom, 8'($urandom));
        send_req(MODE_PEEK_TAIL, $urandom, 8'($urandom));
        rx_idle = 1'b1;
        wait_results_done();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle     = 1'b0;
        hold_cycles = 200;
        repeat (30) send_req(pick_mode(50, 30), $urandom, 8'($urandom));
        tx_idle = 1'b1;
        wait_results_done();
    endtask

    task automatic test_random_mix(int bursts);
        int enq_pct;
        int deq_pct;
        int prio_hi;
        for (int b = 0; b < bursts; b++) begin
            case (b % 6)
                0, 1, 2: begin
                    enq_pct = 85;
                    deq_pct = 5;
                end
                3: begin
                    enq_pct = 40;
                    deq_pct = 40;
                end
                default: begin
                    enq_pct = 10;
                    deq_pct = 75;
                end
            endcase
            prio_hi = (b % 4 == 1) ? 3 : 255;
            tx_idle = (b % 5 != 2);
            rx_idle = (b % 7 != 3);
            repeat (50) send_req(pick_mode(enq_pct, deq_pct), $urandom,
                                 8'($urandom_range(0, prio_hi)));
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // result receiver with random stalls and an occasional long hold
    initial begin
        int stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[STATUS_W-1:0]);
            got.data   = m_tdata[STATUS_W +: DATA_W];
            got.prio   = m_tdata[STATUS_W+DATA_W +: PRIO_W];
            got.fill   = m_tdata[STATUS_W+DATA_W+PRIO_W +: FILL_W];
            results_seen++;
            if (got.status == ST_OVERFLOW)
                overflow_seen++;
            if (got.status == ST_UNDERFLOW)
                underflow_seen++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result beat with nothing expected: status %0d data %h",
                             $realtime, got.status, got.data);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: result %0d mismatch: status %0d/%0d data %h/%h ",
                                  "prio %h/%h fill %0d/%0d (expected/actual)"},
                                 $realtime, results_seen, want.status, got.status,
                                 want.data, got.data, want.prio, got.prio,
                                 want.fill, got.fill);
                end
            end
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_overflow();
        test_backpressure();
        test_random_mix(12);
        wait_results_done();
        repeat (8) @(posedge aclk);
        $display("%0d requests sent, %0d results checked", reqs_sent, results_seen);
        $display("%0d overflow and %0d underflow results, %0d failures",
                 overflow_seen, underflow_seen, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sipq_pkg.sv
hdl/sipq_cell.sv
hdl/sorted_insert_priority_queue.sv
tb/tb.sv
